@@ sv/fma_pkg.sv @@
// ----------------------------------------------------------------------------
// fma_pkg
// Shared widths, constants, the arctangent table and the controller command
// bundle for the field magnitude and angle block.
// ----------------------------------------------------------------------------
package fma_pkg;

  localparam int AXIS_BITS    = 24;
  localparam int OUT_BITS     = 24;
  localparam int SQ_BITS      = 2 * AXIS_BITS;
  localparam int ROOT_STEPS   = AXIS_BITS;
  localparam int CORDIC_STEPS = 24;
  localparam int GUARD_SHIFT  = 24;
  // Operand width of the CORDIC unit, in bits of the input vector.
  localparam int VEC_BITS     = AXIS_BITS + 1;
  // The rotated vector grows by the CORDIC gain and by sqrt(2); three bits cover it.
  localparam int CW           = VEC_BITS + GUARD_SHIFT + 3;
  localparam int ACC_BITS     = 33;
  localparam int IDX_BITS     = 5;
  localparam int CNT_BITS     = 5;
  localparam int ANGLE_LIMIT  = 5898240;

  typedef struct packed {
    logic       load_in;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       root_load;
    logic       root_step;
    logic       cor_load_dec;
    logic       cor_load_inc;
    logic       cor_step;
    logic       dec_save;
    logic       out_load;
  } cmd_t;

  localparam logic [1:0] SQ_SEL_X = 2'd0;
  localparam logic [1:0] SQ_SEL_Z = 2'd1;
  localparam logic [1:0] SQ_SEL_Y = 2'd2;

  // round(atan(2^-i) * 180/pi * 2^24)
  function automatic logic [ACC_BITS-1:0] atan_entry(input logic [IDX_BITS-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd754974720;
      5'd1:  v = 32'd445687602;
      5'd2:  v = 32'd235489088;
      5'd3:  v = 32'd119537938;
      5'd4:  v = 32'd60000934;
      5'd5:  v = 32'd30029717;
      5'd6:  v = 32'd15018523;
      5'd7:  v = 32'd7509720;
      5'd8:  v = 32'd3754917;
      5'd9:  v = 32'd1877466;
      5'd10: v = 32'd938734;
      5'd11: v = 32'd469367;
      5'd12: v = 32'd234684;
      5'd13: v = 32'd117342;
      5'd14: v = 32'd58671;
      5'd15: v = 32'd29335;
      5'd16: v = 32'd14668;
      5'd17: v = 32'd7334;
      5'd18: v = 32'd3667;
      5'd19: v = 32'd1833;
      5'd20: v = 32'd917;
      5'd21: v = 32'd458;
      5'd22: v = 32'd229;
      5'd23: v = 32'd115;
      5'd24: v = 32'd57;
      5'd25: v = 32'd29;
      5'd26: v = 32'd14;
      5'd27: v = 32'd7;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return {1'b0, v};
  endfunction

endpackage

@@ sv/fma_sqrt.sv @@
// ----------------------------------------------------------------------------
// fma_sqrt
// Digit-by-digit integer square root, one result bit per step.
// ----------------------------------------------------------------------------
module fma_sqrt
  import fma_pkg::*;
(
  input  logic                  clk,
  input  logic                  load,
  input  logic                  step,
  input  logic [SQ_BITS-1:0]    radicand,
  output logic [ROOT_STEPS-1:0] root
);

  logic [SQ_BITS-1:0]    rad_sh;
  logic [ROOT_STEPS:0]   rem;
  logic [ROOT_STEPS+2:0] rem_s;
  logic [ROOT_STEPS+2:0] trial;
  logic                  fits;

  assign rem_s = {rem, rad_sh[SQ_BITS-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (load) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
    end else if (step) begin
      rad_sh <= {rad_sh[SQ_BITS-3:0], 2'b00};
      if (fits) begin
        rem  <= (ROOT_STEPS+1)'(rem_s - trial);
        root <= {root[ROOT_STEPS-2:0], 1'b1};
      end else begin
        rem  <= rem_s[ROOT_STEPS:0];
        root <= {root[ROOT_STEPS-2:0], 1'b0};
      end
    end
  end

endmodule

@@ sv/fma_cordic.sv @@
// ----------------------------------------------------------------------------
// fma_cordic
// Vectoring CORDIC for atan(num / den), den >= 0, one step per cycle while
// step is high; angle accumulated in degrees * 2^24, rounded to degrees * 65536.
// ----------------------------------------------------------------------------
module fma_cordic
  import fma_pkg::*;
(
  input  logic                       clk,
  input  logic                       load,
  input  logic                       step,
  input  logic signed [VEC_BITS-1:0] den,
  input  logic signed [VEC_BITS-1:0] num,
  output logic signed [OUT_BITS-1:0] angle
);

  logic signed [CW-1:0]       x;
  logic signed [CW-1:0]       y;
  logic signed [ACC_BITS-1:0] acc;
  logic [IDX_BITS-1:0]        idx;
  logic                       spec;
  logic signed [OUT_BITS-1:0] spec_val;

  logic signed [CW-1:0]         xs;
  logic signed [CW-1:0]         ys;
  logic signed [ACC_BITS-1:0]   tab;
  logic signed [ACC_BITS-1:0]   acc_rnd;
  logic signed [ACC_BITS-9:0]   r;
  logic signed [OUT_BITS-1:0]   r_clamp;

  assign xs  = x >>> idx;
  assign ys  = y >>> idx;
  assign tab = signed'(atan_entry(idx));

  always_ff @(posedge clk) begin
    if (load) begin
      x   <= CW'(den) <<< GUARD_SHIFT;
      y   <= CW'(num) <<< GUARD_SHIFT;
      acc <= '0;
      idx <= '0;
      // A zero divisor gives a right angle by the numerator's sign; a zero
      // numerator gives exactly zero.
      spec <= (den == '0) || (num == '0);
      if (den != '0 || num == '0) begin
        spec_val <= '0;
      end else if (num[VEC_BITS-1]) begin
        spec_val <= -OUT_BITS'(ANGLE_LIMIT);
      end else begin
        spec_val <= OUT_BITS'(ANGLE_LIMIT);
      end
    end else if (step) begin
      idx <= idx + 1'b1;
      if (!y[CW-1]) begin
        x   <= x + ys;
        y   <= y - xs;
        acc <= acc + tab;
      end else begin
        x   <= x - ys;
        y   <= y + xs;
        acc <= acc - tab;
      end
    end
  end

  assign acc_rnd = acc + ACC_BITS'(128);
  assign r       = acc_rnd[ACC_BITS-1:8];

  always_comb begin
    if (r > (ACC_BITS-8)'(ANGLE_LIMIT)) begin
      r_clamp = OUT_BITS'(ANGLE_LIMIT);
    end else if (r < -(ACC_BITS-8)'(ANGLE_LIMIT)) begin
      r_clamp = -OUT_BITS'(ANGLE_LIMIT);
    end else begin
      r_clamp = r[OUT_BITS-1:0];
    end
  end

  assign angle = spec ? spec_val : r_clamp;

endmodule

@@ sv/fma_dp.sv @@
// ----------------------------------------------------------------------------
// fma_dp
// Datapath: input registers, shared squaring multiplier, two square-root
// units, the CORDIC unit and the result registers.
// ----------------------------------------------------------------------------
module fma_dp
  import fma_pkg::*;
(
  input  logic                        clk,
  input  cmd_t                        cmd,
  input  logic signed [AXIS_BITS-1:0] field_x,
  input  logic signed [AXIS_BITS-1:0] field_y,
  input  logic signed [AXIS_BITS-1:0] field_z,
  output logic [OUT_BITS-1:0]         total_intensity,
  output logic [OUT_BITS-1:0]         horizontal_intensity,
  output logic signed [OUT_BITS-1:0]  declination,
  output logic signed [OUT_BITS-1:0]  inclination
);

  logic signed [AXIS_BITS-1:0] fx;
  logic signed [AXIS_BITS-1:0] fy;
  logic signed [AXIS_BITS-1:0] fz;
  logic [SQ_BITS-1:0]          sqx;
  logic [SQ_BITS-1:0]          sqy;
  logic [SQ_BITS-1:0]          sqz;
  logic signed [OUT_BITS-1:0]  dec_angle;

  logic signed [AXIS_BITS-1:0] mul_a;
  logic signed [SQ_BITS-1:0]   prod;
  logic [ROOT_STEPS-1:0]       root_t;
  logic [ROOT_STEPS-1:0]       root_h;
  logic signed [VEC_BITS-1:0]  bx;
  logic signed [VEC_BITS-1:0]  bz;
  logic signed [VEC_BITS-1:0]  cor_den;
  logic signed [VEC_BITS-1:0]  cor_num;
  logic signed [OUT_BITS-1:0]  angle;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      fx <= field_x;
      fy <= field_y;
      fz <= field_z;
    end
  end

  always_comb begin
    case (cmd.sq_sel)
      SQ_SEL_X: mul_a = fx;
      SQ_SEL_Z: mul_a = fz;
      SQ_SEL_Y: mul_a = fy;
      default:  mul_a = fx;
    endcase
  end

  assign prod = mul_a * mul_a;

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      case (cmd.sq_sel)
        SQ_SEL_X: sqx <= unsigned'(prod);
        SQ_SEL_Z: sqz <= unsigned'(prod);
        SQ_SEL_Y: sqy <= unsigned'(prod);
        default:  sqx <= unsigned'(prod);
      endcase
    end
  end

  fma_sqrt u_sqrt_t (
    .clk      (clk),
    .load     (cmd.root_load),
    .step     (cmd.root_step),
    .radicand (sqx + sqy + sqz),
    .root     (root_t)
  );

  fma_sqrt u_sqrt_h (
    .clk      (clk),
    .load     (cmd.root_load),
    .step     (cmd.root_step),
    .radicand (sqx + sqz),
    .root     (root_h)
  );

  // Declination folds a negative X into the right half-plane by negating
  // both X and Z, which keeps the ratio.
  assign bx = VEC_BITS'(fx);
  assign bz = VEC_BITS'(fz);

  always_comb begin
    if (cmd.cor_load_inc) begin
      cor_den = signed'({1'b0, root_h});
      cor_num = VEC_BITS'(fy);
    end else if (fx[AXIS_BITS-1]) begin
      cor_den = -bx;
      cor_num = -bz;
    end else begin
      cor_den = bx;
      cor_num = bz;
    end
  end

  fma_cordic u_cordic (
    .clk   (clk),
    .load  (cmd.cor_load_dec | cmd.cor_load_inc),
    .step  (cmd.cor_step),
    .den   (cor_den),
    .num   (cor_num),
    .angle (angle)
  );

  always_ff @(posedge clk) begin
    if (cmd.dec_save) begin
      dec_angle <= angle;
    end
    if (cmd.out_load) begin
      total_intensity      <= root_t;
      horizontal_intensity <= root_h;
      declination          <= dec_angle;
      inclination          <= angle;
    end
  end

endmodule

@@ sv/fma_ctrl.sv @@
// ----------------------------------------------------------------------------
// fma_ctrl
// Controller: sequences squaring, the square roots with the declination
// CORDIC pass beside them, then the inclination CORDIC pass.
// ----------------------------------------------------------------------------
module fma_ctrl
  import fma_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQUARE = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_ROOT   = 3'd3;
  localparam logic [2:0] S_DECSV  = 3'd4;
  localparam logic [2:0] S_INC    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [CNT_BITS-1:0] cnt;
  logic [CNT_BITS-1:0] cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 1'b1;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (start) begin
          cmd.load_in = 1'b1;
          state_next  = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.sq_en  = 1'b1;
        cmd.sq_sel = cnt[1:0];
        if (cnt[1:0] == SQ_SEL_Y) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.root_load    = 1'b1;
        cmd.cor_load_dec = 1'b1;
        cnt_next         = '0;
        state_next       = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cmd.cor_step  = cnt < CNT_BITS'(CORDIC_STEPS);
        if (cnt == CNT_BITS'(ROOT_STEPS - 1)) begin
          state_next = S_DECSV;
        end
      end
      S_DECSV: begin
        cmd.dec_save     = 1'b1;
        cmd.cor_load_inc = 1'b1;
        cnt_next         = '0;
        state_next       = S_INC;
      end
      S_INC: begin
        cmd.cor_step = 1'b1;
        if (cnt == CNT_BITS'(CORDIC_STEPS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= cmd.out_load;
    end
  end

  assign busy = state != S_IDLE;

endmodule

@@ sv/field_magnitude_and_angles.sv @@
// ----------------------------------------------------------------------------
// field_magnitude_and_angles
// Total and horizontal intensity, declination and inclination of one
// three-axis magnetometer sample, by integer square roots and CORDIC.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   input    | start, busy         | field_x, field_y, field_z
//   result   | done (one cycle)    | total_intensity, horizontal_intensity,
//            |                     | declination, inclination
//
// An item runs from acceptance to done through the squares of X, Z and Y on
// the shared squaring multiplier, 24 square-root steps with the declination
// CORDIC pass running beside them, and 24 CORDIC steps for the inclination.
// busy is high for the whole item; a new item can be accepted in the cycle
// that done is high. Reset returns the controller to idle.
// The receiver cannot stall: results are held only until the next item ends.
// ----------------------------------------------------------------------------
module field_magnitude_and_angles
  import fma_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [AXIS_BITS-1:0] field_x,
  input  logic signed [AXIS_BITS-1:0] field_y,
  input  logic signed [AXIS_BITS-1:0] field_z,
  output logic                        done,
  output logic [OUT_BITS-1:0]         total_intensity,
  output logic [OUT_BITS-1:0]         horizontal_intensity,
  output logic signed [OUT_BITS-1:0]  declination,
  output logic signed [OUT_BITS-1:0]  inclination
);

  cmd_t cmd;

  fma_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  fma_dp u_dp (
    .clk                  (clk),
    .cmd                  (cmd),
    .field_x              (field_x),
    .field_y              (field_y),
    .field_z              (field_z),
    .total_intensity      (total_intensity),
    .horizontal_intensity (horizontal_intensity),
    .declination          (declination),
    .inclination          (inclination)
  );

endmodule
